>>> design/srrw_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window package
// Shared widths, codes and record types for the receive window blocks.
// ----------------------------------------------------------------------------
package srrw_pkg;

    // Window and sequence sizing.
    localparam int MAX_WINDOW   = 32;
    localparam int SEQ_BITS     = 8;
    localparam int SPACE_MAX    = 2 * MAX_WINDOW;
    localparam int IDX_W        = $clog2(SPACE_MAX);
    localparam int WIN_W        = 6;
    localparam int SPACE_W      = WIN_W + 1;
    localparam int LIM_W        = 7;
    localparam int CNT_W        = IDX_W + 1;
    localparam int CFG_W        = 7;
    localparam int CFG_ADDR_W   = 2;

    // Register reset values.
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);
    localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(10);

    // Window width bounds.
    localparam logic [WIN_W-1:0] WIN_MIN = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = CFG_ADDR_W'(1);

    // Result codes.
    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_OUTSIDE = 2'd2,
        KIND_DELIVER = 2'd3
    } t_kind;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACK,
        ST_WALK
    } t_state;

    // Classified arrival passed from front to back.
    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        logic                oos;
    } t_item;

    // One result record.
    typedef struct packed {
        t_kind               kind;
        logic [SEQ_BITS-1:0] seq;
        logic                last;
    } t_result;

endpackage

>>> design/srrw_front.sv
// ----------------------------------------------------------------------------
// Receive window front end
// Accepts arrivals, flags numbers beyond the sequence space and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module srrw_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [srrw_pkg::SEQ_BITS-1:0]      i_seq_num,
    input  logic [srrw_pkg::SPACE_W-1:0]       i_space,
    output logic                               o_item_valid,
    output srrw_pkg::t_item                    o_item,
    input  logic                               i_item_pop
);

    srrw_pkg::t_item r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            do_push;
    logic            do_pop;
    srrw_pkg::t_item in_item;

    // Classify the arrival against the sequence space.
    always_comb begin
        in_item.seq = i_seq_num;
        in_item.oos = (i_seq_num >= srrw_pkg::SEQ_BITS'(i_space));
    end

    assign full         = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rd];
    assign do_push      = push && !full;
    assign do_pop       = i_item_pop && o_item_valid;

    // Occupancy after this cycle's transfers.
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= in_item;
        end
    end

endmodule

>>> design/srrw_back.sv
// ----------------------------------------------------------------------------
// Receive window back end
// Holds the configuration, the held map, the window base and the held count.
// Decides each arrival, then walks the in-order releases one per cycle while
// results can be pushed. The held map is a memory with registered reads; a
// clearing pass empties it after reset and after every window width write.
// ----------------------------------------------------------------------------
module srrw_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [srrw_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [srrw_pkg::CFG_W-1:0]         i_cfg_data,
    output logic [srrw_pkg::SPACE_W-1:0]       o_space,
    input  logic                               i_item_valid,
    input  srrw_pkg::t_item                    i_item,
    output logic                               o_item_pop,
    input  logic                               i_res_full,
    output logic                               o_res_push,
    output srrw_pkg::t_result                  o_res
);

    // Configuration registers.
    logic [srrw_pkg::WIN_W-1:0]     r_window;
    logic [srrw_pkg::LIM_W-1:0]     r_limit;

    // Held map storage and its ports.
    logic                           r_held [srrw_pkg::SPACE_MAX];
    logic                           r_rd_a;
    logic                           r_rd_b;
    logic [srrw_pkg::IDX_W-1:0]     rd_a_addr;
    logic [srrw_pkg::IDX_W-1:0]     rd_b_addr;
    logic                           mem_we;
    logic [srrw_pkg::IDX_W-1:0]     mem_waddr;
    logic                           mem_wdata;

    // Window state.
    logic [srrw_pkg::IDX_W-1:0]     r_base;
    logic [srrw_pkg::IDX_W-1:0]     n_base;
    logic [srrw_pkg::CNT_W-1:0]     r_count;
    logic [srrw_pkg::CNT_W-1:0]     n_count;
    logic [srrw_pkg::WIN_W-1:0]     r_walk;
    logic [srrw_pkg::WIN_W-1:0]     n_walk;
    logic [srrw_pkg::IDX_W-1:0]     r_seq;
    logic [srrw_pkg::IDX_W-1:0]     n_seq;
    logic                           r_fwd;
    logic                           n_fwd;
    logic [srrw_pkg::IDX_W-1:0]     r_clr;
    logic [srrw_pkg::IDX_W-1:0]     n_clr;
    srrw_pkg::t_state               r_state;
    srrw_pkg::t_state               n_state;

    logic [srrw_pkg::WIN_W-1:0]     win;
    logic [srrw_pkg::SPACE_W-1:0]   space;
    logic [srrw_pkg::IDX_W-1:0]     seq_idx;
    logic [srrw_pkg::SPACE_W:0]     off_sum;
    logic [srrw_pkg::SPACE_W:0]     offset;
    logic [srrw_pkg::IDX_W-1:0]     next_base;
    logic [srrw_pkg::IDX_W-1:0]     after_next;
    logic [srrw_pkg::WIN_W-1:0]     walk_inc;
    logic                           held_next;
    logic                           cont;

    // Effective window width, saturated to its legal range.
    always_comb begin
        if (r_window < srrw_pkg::WIN_MIN) begin
            win = srrw_pkg::WIN_MIN;
        end else if (r_window > srrw_pkg::WIN_MAX) begin
            win = srrw_pkg::WIN_MAX;
        end else begin
            win = r_window;
        end
    end

    assign space   = {win, 1'b0};
    assign o_space = space;

    // Distance of the arrival from the base, modulo the sequence space.
    assign seq_idx = i_item.seq[srrw_pkg::IDX_W-1:0];
    assign off_sum = (srrw_pkg::SPACE_W+1)'(seq_idx) + (srrw_pkg::SPACE_W+1)'(space)
                   - (srrw_pkg::SPACE_W+1)'(r_base);
    assign offset  = (off_sum >= (srrw_pkg::SPACE_W+1)'(space))
                   ? off_sum - (srrw_pkg::SPACE_W+1)'(space) : off_sum;

    // Base after one and after two releases, wrapping at the sequence space.
    assign next_base  = ((srrw_pkg::SPACE_W)'(r_base) + 1'b1 == space)
                      ? '0 : r_base + 1'b1;
    assign after_next = ((srrw_pkg::SPACE_W)'(next_base) + 1'b1 == space)
                      ? '0 : next_base + 1'b1;
    assign walk_inc   = r_walk + 1'b1;

    // The entry after the base is held if the prefetch says so or if the
    // acknowledgement just marked it.
    assign held_next  = r_rd_b || r_fwd;

    // Decision, release walk, map clearing and configuration writes.
    always_comb begin
        n_base     = r_base;
        n_count    = r_count;
        n_walk     = r_walk;
        n_seq      = r_seq;
        n_fwd      = r_fwd;
        n_clr      = r_clr;
        n_state    = r_state;
        rd_a_addr  = r_seq;
        rd_b_addr  = r_base;
        mem_we     = 1'b0;
        mem_waddr  = r_base;
        mem_wdata  = 1'b0;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res.kind = srrw_pkg::KIND_ACK;
        o_res.seq  = i_item.seq;
        o_res.last = 1'b1;
        cont       = 1'b0;

        unique case (r_state)
            srrw_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 1'b0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == srrw_pkg::IDX_W'(srrw_pkg::SPACE_MAX - 1)) begin
                    n_state = srrw_pkg::ST_IDLE;
                end
            end
            srrw_pkg::ST_IDLE: begin
                if (i_item_valid && !i_res_full) begin
                    o_item_pop = 1'b1;
                    if (r_count >= srrw_pkg::CNT_W'(r_limit)) begin
                        o_res_push = 1'b1;
                        o_res.kind = srrw_pkg::KIND_FULL;
                    end else if (i_item.oos ||
                                 offset >= (srrw_pkg::SPACE_W+1)'(win)) begin
                        o_res_push = 1'b1;
                        o_res.kind = srrw_pkg::KIND_OUTSIDE;
                    end else begin
                        // Look up the arrival and the base in the held map.
                        rd_a_addr = seq_idx;
                        rd_b_addr = r_base;
                        n_seq     = seq_idx;
                        n_state   = srrw_pkg::ST_ACK;
                    end
                end
            end
            srrw_pkg::ST_ACK: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.kind = srrw_pkg::KIND_ACK;
                    o_res.seq  = srrw_pkg::SEQ_BITS'(r_seq);
                    mem_we     = 1'b1;
                    mem_waddr  = r_seq;
                    mem_wdata  = 1'b1;
                    if (!r_rd_a) begin
                        n_count = r_count + 1'b1;
                    end
                    cont       = r_rd_b || (r_seq == r_base);
                    o_res.last = !cont;
                    // Prefetch the entry after the base for the walk.
                    rd_b_addr  = next_base;
                    n_fwd      = (next_base == r_seq);
                    if (cont) begin
                        n_state = srrw_pkg::ST_WALK;
                        n_walk  = '0;
                    end else begin
                        n_state = srrw_pkg::ST_IDLE;
                    end
                end
            end
            srrw_pkg::ST_WALK: begin
                rd_b_addr = next_base;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.kind = srrw_pkg::KIND_DELIVER;
                    o_res.seq  = srrw_pkg::SEQ_BITS'(r_base);
                    mem_we     = 1'b1;
                    mem_waddr  = r_base;
                    mem_wdata  = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_base     = next_base;
                    n_walk     = walk_inc;
                    rd_b_addr  = after_next;
                    n_fwd      = 1'b0;
                    cont       = (walk_inc < win) && held_next;
                    o_res.last = !cont;
                    if (!cont) begin
                        n_state = srrw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = srrw_pkg::ST_IDLE;
            end
        endcase

        // A new window width starts an empty window.
        if (i_cfg_we && i_cfg_addr == srrw_pkg::REG_WINDOW) begin
            n_base  = '0;
            n_count = '0;
            n_clr   = '0;
            n_state = srrw_pkg::ST_CLEAR;
        end
    end

    // Held map memory with registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_held[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_held[rd_a_addr];
        r_rd_b <= r_held[rd_b_addr];
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srrw_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
            r_walk  <= '0;
            r_seq   <= '0;
            r_fwd   <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_base  <= n_base;
            r_count <= n_count;
            r_walk  <= n_walk;
            r_seq   <= n_seq;
            r_fwd   <= n_fwd;
            r_clr   <= n_clr;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= srrw_pkg::WINDOW_RESET;
            r_limit  <= srrw_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == srrw_pkg::REG_WINDOW) begin
                r_window <= i_cfg_data[srrw_pkg::WIN_W-1:0];
            end else if (i_cfg_addr == srrw_pkg::REG_LIMIT) begin
                r_limit <= i_cfg_data[srrw_pkg::LIM_W-1:0];
            end
        end
    end

    // Held numbers always lie inside the window, so the count never exceeds it.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srrw_pkg::CNT_W'(win))
        else $error("held count exceeds window");

    // The base always lies inside the sequence space.
    a_base_in_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srrw_pkg::SPACE_W'(r_base) < space)
        else $error("window base outside sequence space");

    // A release walk never covers more than one window.
    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == srrw_pkg::ST_WALK |-> r_walk < win)
        else $error("release walk exceeded window");

    // Results are only written into a queue with room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result transfer into full queue");

    // A walk that ends returns to accepting arrivals.
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.last && !i_cfg_we) |=> r_state == srrw_pkg::ST_IDLE)
        else $error("sequencer stayed busy after final result");

    // Nothing moves while the held map is being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == srrw_pkg::ST_CLEAR |-> !o_item_pop && !o_res_push)
        else $error("transfer during held map clearing");

endmodule

>>> design/srrw_outq.sv
// ----------------------------------------------------------------------------
// Receive window result queue
// Two-entry queue that separates the back end from the result consumer.
// ----------------------------------------------------------------------------
module srrw_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  srrw_pkg::t_result   i_res,
    output logic                o_full,
    output logic                empty,
    input  logic                pop,
    output srrw_pkg::t_result   o_res
);

    srrw_pkg::t_result r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;

    // Occupancy after this cycle's transfers.
    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

>>> design/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window
// Acknowledges or refuses arriving sequence numbers and releases held
// numbers in order from the window base.
//
//   Channel   Direction  Handshake            Payload
//   arrival   in         push / full          i_seq_num
//   result    out        empty / pop          o_kind, o_seq_out, o_last
//   config    in         i_cfg_we             i_cfg_addr, i_cfg_data
//
// A refusal is decided in the idle state; an acknowledgement takes a
// held-map read, then the decision, then a release walk of at most one
// window of numbers. Reset is synchronous; it empties both queues and the
// base, then a clearing pass empties the held map. Every window_size write
// starts the same pass, and arrivals wait in the front queue until it ends.
// Either side may stall: two-entry queues on the arrival and result sides
// let the front end and the back end run on their own.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [srrw_pkg::SEQ_BITS-1:0]      i_seq_num,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_kind,
    output logic [srrw_pkg::SEQ_BITS-1:0]      o_seq_out,
    output logic                               o_last,
    input  logic                               i_cfg_we,
    input  logic [srrw_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [srrw_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [srrw_pkg::SPACE_W-1:0] space;
    logic                         item_valid;
    srrw_pkg::t_item              item;
    logic                         item_pop;
    logic                         res_full;
    logic                         res_push;
    srrw_pkg::t_result            res_in;
    srrw_pkg::t_result            res_out;

    // Arrival intake and classification.
    srrw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_seq_num    (i_seq_num),
        .i_space      (space),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // Window decision and release walk.
    srrw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_space      (space),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    // Result queue toward the consumer.
    srrw_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    // Result fields.
    assign o_kind    = res_out.kind;
    assign o_seq_out = res_out.seq;
    assign o_last    = res_out.last;

endmodule

>>> sim/srrw_window_checker.sv
// ----------------------------------------------------------------------------
// Receive window result checker
// Watches the arrival, result and register ports of the receive window. It
// keeps its own copy of the held map, window base and registers, works out
// the results owed for each arrival and compares every result transfer with
// the oldest one owed.
// ----------------------------------------------------------------------------
module srrw_window_checker
    import srrw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_full,
    input  logic [SEQ_BITS-1:0]    i_seq_num,
    input  logic                   i_empty,
    input  logic                   i_pop,
    input  logic [1:0]             i_kind,
    input  logic [SEQ_BITS-1:0]    i_seq_out,
    input  logic                   i_last,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);

    // Shadow copy of the window state and registers.
    logic                 held_mark [SPACE_MAX];
    logic [IDX_W-1:0]     base_seq;
    logic [CNT_W-1:0]     held_total;
    logic [WIN_W-1:0]     win_field;
    logic [LIM_W-1:0]     limit_field;

    // Results owed to the result port, oldest first.
    t_result              owed_results [$];
    int                   fail_count = 0;
    int                   owed_count = 0;

    assign o_errors  = fail_count;
    assign o_pending = owed_count;

    // Empty the held map and return the base to zero.
    function automatic void clear_window();
        for (int i = 0; i < SPACE_MAX; i++) begin
            held_mark[i] = 1'b0;
        end
        base_seq   = '0;
        held_total = '0;
    endfunction

    // Effective window width: the register saturated to 1..MAX_WINDOW.
    function automatic logic [SPACE_W-1:0] window_width();
        if (win_field < WIN_MIN) begin
            return SPACE_W'(WIN_MIN);
        end
        if (win_field > WIN_MAX) begin
            return SPACE_W'(WIN_MAX);
        end
        return SPACE_W'(win_field);
    endfunction

    function automatic void owe(input t_kind kind, input logic [SEQ_BITS-1:0] seq,
                                input logic last);
        t_result r;
        r.kind = kind;
        r.seq  = seq;
        r.last = last;
        owed_results.push_back(r);
    endfunction

    // Decide an arrival and walk the in-order releases that follow it.
    function automatic void admit_arrival(input logic [SEQ_BITS-1:0] seq);
        logic [SPACE_W-1:0]  w;
        logic [SPACE_W-1:0]  space;
        logic [SEQ_BITS:0]   offset;
        int                  walked;
        t_result             r;
        w     = window_width();
        space = w << 1;
        // The buffer-full test wins over the window test.
        if (held_total >= limit_field) begin
            owe(KIND_FULL, seq, 1'b1);
            return;
        end
        if (seq >= space || base_seq >= space) begin
            owe(KIND_OUTSIDE, seq, 1'b1);
            return;
        end
        offset = ((SEQ_BITS+1)'(seq) + space - base_seq) % space;
        if (offset >= w) begin
            owe(KIND_OUTSIDE, seq, 1'b1);
            return;
        end
        // A duplicate is acknowledged again without changing the count.
        if (!held_mark[seq[IDX_W-1:0]]) begin
            held_mark[seq[IDX_W-1:0]] = 1'b1;
            held_total++;
        end
        owe(KIND_ACK, seq, 1'b0);
        walked = 0;
        while (walked < w && held_mark[base_seq]) begin
            held_mark[base_seq] = 1'b0;
            if (held_total > 0) begin
                held_total--;
            end
            owe(KIND_DELIVER, SEQ_BITS'(base_seq), 1'b0);
            base_seq = IDX_W'((SPACE_W'(base_seq) + SPACE_W'(1)) % space);
            walked++;
        end
        // Flag the final result of this arrival.
        r = owed_results.pop_back();
        r.last = 1'b1;
        owed_results.push_back(r);
    endfunction

    // Compare one result transfer with the oldest result owed.
    function automatic void check_transfer();
        t_result want;
        if (owed_results.size() == 0) begin
            $display("%0t: unowed result, actual kind %0d seq %0d last %0d",
                     $time, i_kind, i_seq_out, i_last);
            fail_count++;
            return;
        end
        want = owed_results.pop_front();
        if (want.kind != t_kind'(i_kind)) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, i_kind);
            fail_count++;
        end
        if (want.seq != i_seq_out) begin
            $display("%0t: seq_out mismatch, expected %0d, actual %0d",
                     $time, want.seq, i_seq_out);
            fail_count++;
        end
        if (want.last != i_last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d",
                     $time, want.last, i_last);
            fail_count++;
        end
    endfunction

    // Track every transfer at the clock edge where it happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_field   = WINDOW_RESET;
            limit_field = LIMIT_RESET;
            clear_window();
            owed_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                check_transfer();
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_WINDOW: begin
                        win_field = i_cfg_data[WIN_W-1:0];
                        clear_window();
                    end
                    REG_LIMIT: begin
                        limit_field = i_cfg_data[LIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_push && !i_full) begin
                admit_arrival(i_seq_num);
            end
        end
        owed_count = owed_results.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Receive window testbench
// Drives arriving sequence numbers and register writes into the receive
// window, drains results with random stalls, and leaves prediction and
// comparison to the checker. A directed opening covers the special cases;
// random phases then send window-ordered batches with strays and duplicates,
// plus noise phases, over many window and buffer limit settings.
// ----------------------------------------------------------------------------
module tb;
    import srrw_pkg::*;

    // Register indexes that the block ignores.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = CFG_ADDR_W'(3);
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 80;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   push       = 1'b0;
    logic                   full;
    logic [SEQ_BITS-1:0]    i_seq_num  = '0;
    logic                   empty;
    logic                   pop        = 1'b0;
    logic [1:0]             o_kind;
    logic [SEQ_BITS-1:0]    o_seq_out;
    logic                   o_last;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    int                     errors;
    int                     pending;

    // Stimulus-side view of the window, used only to shape batches.
    int                     win_now    = 3;
    int                     space_now  = 6;
    int                     limit_now  = 10;
    int                     tx_base    = 0;
    int                     sent_count = 0;
    logic                   calm       = 1'b0;

    selective_repeat_receive_window dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_seq_num  (i_seq_num),
        .empty      (empty),
        .pop        (pop),
        .o_kind     (o_kind),
        .o_seq_out  (o_seq_out),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    srrw_window_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_seq_num  (i_seq_num),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_kind     (o_kind),
        .i_seq_out  (o_seq_out),
        .i_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // Result side: stall at random, then hold pop until one transfer.
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    // Send one arrival and return at the edge of its transfer.
    task automatic send_packet(input int seq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_seq_num <= SEQ_BITS'(seq);
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sent_count++;
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // One register write; the block must be idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
        int w;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= CFG_W'(data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (addr == REG_WINDOW) begin
            w = data & 63;
            win_now   = (w < 1) ? 1 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
            space_now = 2 * win_now;
            tx_base   = 0;
        end else if (addr == REG_LIMIT) begin
            limit_now = data & 127;
        end
    endtask

    function automatic int pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return $urandom_range(1, 8);
        end
        if (r < 75) begin
            case ($urandom_range(0, 4))
                0:       return 0;
                1:       return 32;
                2:       return 33;
                3:       return 63;
                default: return 127;
            endcase
        end
        return $urandom_range(0, 127);
    endfunction

    function automatic int pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return $urandom_range(win_now, 64);
        end
        if (r < 70) begin
            return $urandom_range(1, 3);
        end
        if (r < 75) begin
            return 0;
        end
        if (r < 85) begin
            return 127;
        end
        return $urandom_range(0, 127);
    endfunction

    // Well-formed traffic: each batch covers the whole window in some order,
    // with strays behind the window or past the sequence space and duplicates.
    task automatic run_batches();
        int batches;
        int style;
        int j;
        int tmp;
        int order [$];
        batches = $urandom_range(1, 4);
        for (int b = 0; b < batches; b++) begin
            order.delete();
            for (int k = 0; k < win_now; k++) begin
                order.push_back(k);
            end
            style = $urandom_range(0, 9);
            if (style < 2) begin
                // Reversed order holds the whole window, then releases it at once.
                for (int k = 0; k < win_now; k++) begin
                    order[k] = win_now - 1 - k;
                end
            end else if (style >= 3) begin
                for (int k = win_now - 1; k > 0; k--) begin
                    j        = $urandom_range(0, k);
                    tmp      = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
            end
            for (int k = 0; k < win_now; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_packet($urandom_range(space_now, 255));
                    end else begin
                        send_packet((tx_base + space_now - 1) % space_now);
                    end
                end
                send_packet((tx_base + order[k]) % space_now);
                if ($urandom_range(0, 9) == 0) begin
                    send_packet((tx_base + order[$urandom_range(0, k)]) % space_now);
                end
            end
            // Retransmitting a delivered batch only draws refusals.
            if ($urandom_range(0, 4) == 0) begin
                for (int k = 0; k < win_now; k++) begin
                    send_packet((tx_base + k) % space_now);
                end
            end
            tx_base = (tx_base + win_now) % space_now;
        end
    endtask

    // Unordered traffic, mostly inside the sequence space.
    task automatic run_noise();
        int count;
        int r;
        count = $urandom_range(5, 25);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_packet($urandom_range(0, space_now - 1));
            end else if (r < 80) begin
                send_packet($urandom_range(0, 255));
            end else begin
                send_packet($urandom_range(0, 2 * space_now));
            end
        end
    endtask

    // Main sequence: reset, directed cases, random phases, verdict.
    initial begin
        int   start_count;
        logic force_clear;
        logic tracked;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: in-order delivery, a gap filled later, a duplicate,
        // numbers past the sequence space, one behind the window, and a
        // release walk that wraps the base back to zero.
        send_packet(0);
        send_packet(2);
        send_packet(2);
        send_packet(1);
        send_packet(6);
        send_packet(255);
        send_packet(0);
        send_packet(5);
        send_packet(4);
        send_packet(3);
        wait_drained();

        // Buffer full wins over the window test, even for the base number.
        write_reg(REG_LIMIT, 1);
        send_packet(1);
        send_packet(200);
        send_packet(0);
        wait_drained();

        // Ignored indexes, a zero limit and a zero window width.
        write_reg(REG_SPARE_A, 127);
        write_reg(REG_SPARE_B, 0);
        write_reg(REG_LIMIT, 0);
        write_reg(REG_WINDOW, 0);
        send_packet(0);
        wait_drained();

        // Window of one: space of two numbers.
        write_reg(REG_LIMIT, 127);
        send_packet(0);
        send_packet(1);
        send_packet(2);
        send_packet(1);
        wait_drained();

        // Oversized width saturates to the largest window.
        write_reg(REG_WINDOW, 127);
        send_packet(63);
        send_packet(31);
        send_packet(32);
        send_packet(64);
        send_packet(0);
        wait_drained();

        // Random phases, each under fresh register settings.
        start_count = sent_count;
        force_clear = 1'b1;
        while (sent_count - start_count < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if (force_clear || $urandom_range(0, 9) < 6) begin
                write_reg(REG_WINDOW, pick_window());
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          $urandom_range(0, 127));
            end
            write_reg(REG_LIMIT, pick_limit());
            // A limit below the window can stall the base, so the
            // stimulus loses track of it and the next phase clears.
            tracked = (limit_now >= win_now);
            if (tracked && $urandom_range(0, 4) != 0) begin
                run_batches();
                force_clear = 1'b0;
            end else begin
                run_noise();
                force_clear = 1'b1;
            end
            wait_drained();
        end

        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
